// File: rtl/stable_priority_queue_with_removal_top_defines.svh
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_WITH_REMOVAL_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_WITH_REMOVAL_TOP_DEFINES_SVH
`ifndef SYNTH
`define SPQR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spqr assertion failed");
`define SPQR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spqr assertion failed");
`else
`define SPQR_ASSERT_SAME(label, ante, cons)
`define SPQR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/spqr_pkg.sv
// Package with sizes, codes and the slot type of the priority queue.
package spqr_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ID_W = 16;
   localparam int PRI_W = 8;
   localparam int OCC_W = 5;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] CMD_SERVE = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [PRI_W-1:0] pri;
   } slot_type;
endpackage

// File: rtl/stable_priority_queue_with_removal_top.sv
// Top level of the stable priority queue with removal by id.
//
// Requests arrive on the req_ channel (command, id, priority) and each gives
// exactly one response on the rsp_ channel (status, served entry, occupancy).
// An item moves when valid is high and stall is low at a rising clock edge.
// The entries sit in one slot memory, head at slot zero, read one slot per
// cycle through a registered read port while the shifted slots are written back.
// A remove or serve walks every held slot, and an insert walks from the
// tail until its place is found. An update is a remove walk followed by an
// insert walk. A remove or serve on an empty queue and an insert on a full
// one answer without a walk, and an insert or update on an empty queue
// writes slot zero directly. The block goes back to idle as the response is
// loaded and takes the next request from there.
// A finished response waits in the output register while the next request is
// taken; a stalled response holds, and the block waits before completing the
// following command until that response has gone.
// Reset empties the queue and drops any pending response; the slot memory
// needs no clearing pass.
module stable_priority_queue_with_removal_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_cmd,
   input  logic [spqr_pkg::ID_W-1:0] req_entry_id,
   input  logic [spqr_pkg::PRI_W-1:0] req_entry_priority,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [spqr_pkg::ID_W-1:0] rsp_served_id,
   output logic [spqr_pkg::PRI_W-1:0] rsp_served_priority,
   output logic [spqr_pkg::OCC_W-1:0] rsp_occupancy
);
   import spqr_pkg::*;
`include "stable_priority_queue_with_removal_top_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RM_WALK,
      ST_INS_WALK,
      ST_INS_PUT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [PRI_W-1:0] pri_ff, pri_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] rptr_ff, rptr_in;
   logic [IDX_W-1:0] ridx_ff;
   logic iss_ff, iss_in;
   logic rvld_ff, rvld_in;
   logic found_ff, found_in;
   logic [1:0] st_ff, st_in;
   slot_type srv_ff, srv_in;
   slot_type rdata_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   slot_type rsp_srv_ff, rsp_srv_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type wr_data;
   logic start_ins;
   logic [CNT_W-1:0] ins_fill;
   logic match;
   logic hit;
   logic [CNT_W-1:0] fill_m1;

   slot_type mem [DEPTH];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_served_id = rsp_srv_ff.id;
   assign rsp_served_priority = rsp_srv_ff.pri;
   assign rsp_occupancy = rsp_occ_ff;
   assign fill_m1 = fill_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      id_in = id_ff;
      pri_in = pri_ff;
      fill_in = fill_ff;
      rptr_in = rptr_ff;
      iss_in = iss_ff;
      rvld_in = 1'b0;
      found_in = found_ff;
      st_in = st_ff;
      srv_in = srv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_srv_in = rsp_srv_ff;
      rsp_occ_in = rsp_occ_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      start_ins = 1'b0;
      ins_fill = fill_ff;
      match = 1'b0;
      hit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               id_in = req_entry_id;
               pri_in = req_entry_priority;
               srv_in = '0;
               found_in = 1'b0;
               st_in = STATUS_OK;
               if (req_cmd == CMD_INSERT) begin
                  start_ins = 1'b1;
               end else if (fill_ff == '0) begin
                  st_in = STATUS_EMPTY;
                  if (req_cmd == CMD_UPDATE) begin
                     start_ins = 1'b1;
                  end else begin
                     state_in = ST_RESP;
                  end
               end else begin
                  state_in = ST_RM_WALK;
                  rptr_in = '0;
                  iss_in = 1'b1;
               end
            end
         end
         ST_RM_WALK: begin
            rvld_in = iss_ff;
            if (iss_ff) begin
               if (CNT_W'(rptr_ff) == fill_m1) begin
                  iss_in = 1'b0;
               end else begin
                  rptr_in = rptr_ff + IDX_W'(1);
               end
            end
            if (rvld_ff) begin
               match = (cmd_ff == CMD_SERVE) ? (ridx_ff == '0) : (rdata_ff.id == id_ff);
               if (found_ff) begin
                  wr_en = 1'b1;
                  wr_addr = ridx_ff - IDX_W'(1);
                  wr_data = rdata_ff;
               end else if (match) begin
                  found_in = 1'b1;
                  if (cmd_ff == CMD_SERVE) begin
                     srv_in = rdata_ff;
                  end
               end
               if (CNT_W'(ridx_ff) == fill_m1) begin
                  hit = found_ff || match;
                  fill_in = hit ? fill_m1 : fill_ff;
                  st_in = hit ? STATUS_OK : STATUS_NOT_FOUND;
                  iss_in = 1'b0;
                  rvld_in = 1'b0;
                  if (cmd_ff == CMD_UPDATE) begin
                     start_ins = 1'b1;
                     ins_fill = hit ? fill_m1 : fill_ff;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end
         end
         ST_INS_WALK: begin
            rvld_in = iss_ff;
            if (iss_ff) begin
               if (rptr_ff == '0) begin
                  iss_in = 1'b0;
               end else begin
                  rptr_in = rptr_ff - IDX_W'(1);
               end
            end
            if (rvld_ff) begin
               wr_en = 1'b1;
               wr_addr = ridx_ff + IDX_W'(1);
               if (rdata_ff.pri >= pri_ff) begin
                  wr_data.id = id_ff;
                  wr_data.pri = pri_ff;
                  fill_in = fill_ff + CNT_W'(1);
                  iss_in = 1'b0;
                  rvld_in = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  wr_data = rdata_ff;
                  if (ridx_ff == '0) begin
                     rvld_in = 1'b0;
                     state_in = ST_INS_PUT;
                  end
               end
            end
         end
         ST_INS_PUT: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data.id = id_ff;
            wr_data.pri = pri_ff;
            fill_in = fill_ff + CNT_W'(1);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_srv_in = srv_ff;
               rsp_occ_in = OCC_W'(fill_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (start_ins) begin
         if (ins_fill == CNT_W'(DEPTH)) begin
            st_in = STATUS_FULL;
            state_in = ST_RESP;
         end else if (ins_fill == '0) begin
            state_in = ST_INS_PUT;
         end else begin
            state_in = ST_INS_WALK;
            rptr_in = IDX_W'(ins_fill - CNT_W'(1));
            iss_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         iss_ff <= 1'b0;
         rvld_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         iss_ff <= iss_in;
         rvld_ff <= rvld_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      id_ff <= id_in;
      pri_ff <= pri_in;
      rptr_ff <= rptr_in;
      ridx_ff <= rptr_ff;
      st_ff <= st_in;
      srv_ff <= srv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_srv_ff <= rsp_srv_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rptr_ff];
   end

   `SPQR_ASSERT_SAME(a_fill_bound, 1'b1, fill_ff <= CNT_W'(DEPTH))
   `SPQR_ASSERT_SAME(a_write_in_range, wr_en, CNT_W'(wr_addr) <= fill_ff)
   `SPQR_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != ST_IDLE)
   `SPQR_ASSERT_NEXT(a_idle_keeps_fill, state_ff == ST_IDLE, $stable(fill_ff))
endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the stable priority queue with removal by id.
`timescale 1ns / 1ps

module tb_top;
   import spqr_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_REQUESTS = 570;

   typedef struct packed {
      logic [1:0] status;
      logic [ID_W-1:0] served_id;
      logic [PRI_W-1:0] served_priority;
      logic [OCC_W-1:0] occupancy;
   } queue_answer_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = CMD_SERVE;
   logic [ID_W-1:0] req_entry_id = '0;
   logic [PRI_W-1:0] req_entry_priority = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [ID_W-1:0] rsp_served_id;
   logic [PRI_W-1:0] rsp_served_priority;
   logic [OCC_W-1:0] rsp_occupancy;

   logic [ID_W-1:0] held_ids[$];
   logic [PRI_W-1:0] held_pris[$];
   queue_answer_type pending_answers[$];

   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int burst_left = 0;
   bit hold_off_request = 1'b0;
   int hold_left = 0;
   int pattern_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   stable_priority_queue_with_removal_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_entry_id(req_entry_id),
      .req_entry_priority(req_entry_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_served_id(rsp_served_id),
      .rsp_served_priority(rsp_served_priority),
      .rsp_occupancy(rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: timed out after %0d cycles", CYCLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic logic [1:0] held_insert(logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
      int pos;
      if (held_ids.size() >= DEPTH) return STATUS_FULL;
      pos = 0;
      while (pos < held_ids.size() && held_pris[pos] >= pri) pos++;
      held_ids.insert(pos, id);
      held_pris.insert(pos, pri);
      return STATUS_OK;
   endfunction

   function automatic logic [1:0] held_remove(logic [ID_W-1:0] id);
      int pos;
      if (held_ids.size() == 0) return STATUS_EMPTY;
      pos = 0;
      while (pos < held_ids.size() && held_ids[pos] != id) pos++;
      if (pos >= held_ids.size()) return STATUS_NOT_FOUND;
      held_ids.delete(pos);
      held_pris.delete(pos);
      return STATUS_OK;
   endfunction

   function automatic queue_answer_type predict_answer(logic [1:0] cmd, logic [ID_W-1:0] id,
                                                       logic [PRI_W-1:0] pri);
      queue_answer_type answer;
      logic [1:0] removed;
      answer = '0;
      case (cmd)
         CMD_INSERT: answer.status = held_insert(id, pri);
         CMD_REMOVE: answer.status = held_remove(id);
         CMD_UPDATE: begin
            removed = held_remove(id);
            answer.status = (held_insert(id, pri) == STATUS_FULL) ? STATUS_FULL : removed;
         end
         default: begin
            if (held_ids.size() == 0) begin
               answer.status = STATUS_EMPTY;
            end else begin
               answer.status = STATUS_OK;
               answer.served_id = held_ids.pop_front();
               answer.served_priority = held_pris.pop_front();
            end
         end
      endcase
      answer.occupancy = OCC_W'(held_ids.size());
      return answer;
   endfunction

   task automatic send_request(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                               input logic [PRI_W-1:0] pri);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_entry_id <= id;
      req_entry_priority <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_answers.push_back(predict_answer(cmd, id, pri));
      requests_sent++;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string field, input int want, input int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      queue_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_checked++;
         status_seen[rsp_status]++;
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing expected, expected none, actual status %0h",
                     $time, rsp_status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status)
               report_field("status", want.status, rsp_status);
            if (rsp_served_id !== want.served_id)
               report_field("served_id", want.served_id, rsp_served_id);
            if (rsp_served_priority !== want.served_priority)
               report_field("served_priority", want.served_priority, rsp_served_priority);
            if (rsp_occupancy !== want.occupancy)
               report_field("occupancy", want.occupancy, rsp_occupancy);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(8, 60);
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         pattern_left--;
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   task automatic test_directed_commands();
      send_request(CMD_SERVE, 16'h0000, 8'h00);
      send_request(CMD_REMOVE, 16'h0000, 8'h00);
      send_request(CMD_UPDATE, 16'hFFFF, 8'hFF);
      send_request(CMD_INSERT, 16'h0000, 8'h00);
      send_request(CMD_INSERT, 16'hAAAA, 8'hFF);
      send_request(CMD_INSERT, 16'h5555, 8'h80);
      send_request(CMD_INSERT, 16'h5555, 8'h07);
      send_request(CMD_REMOVE, 16'h1234, 8'h00);
      send_request(CMD_REMOVE, 16'h5555, 8'h00);
      send_request(CMD_UPDATE, 16'hAAAA, 8'h01);
      send_request(CMD_UPDATE, 16'h0000, 8'h00);
      send_request(CMD_SERVE, 16'hFFFF, 8'hFF);
      send_request(CMD_INSERT, 16'h8001, 8'h80);
      wait_for_answers();
   endtask

   task automatic test_receiver_hold_off();
      hold_off_request = 1'b1;
      for (int n = 0; n < 24; n++)
         send_request(CMD_INSERT, ID_W'($urandom), PRI_W'($urandom));
      wait_for_answers();
   endtask

   task automatic test_full_queue();
      logic [ID_W-1:0] absent;
      int drain_count;
      send_request(CMD_INSERT, 16'h1357, 8'hC8);
      send_request(CMD_UPDATE, held_ids[held_ids.size() - 1], 8'hFF);
      absent = '0;
      for (int k = 0; k < held_ids.size(); k++) begin
         if (held_ids[k] == absent) begin
            absent++;
            k = -1;
         end
      end
      send_request(CMD_UPDATE, absent, 8'h10);
      send_request(CMD_REMOVE, absent, 8'h00);
      drain_count = held_ids.size() + 1;
      repeat (drain_count) send_request(CMD_SERVE, ID_W'($urandom), PRI_W'($urandom));
      wait_for_answers();
   endtask

   task automatic test_random_traffic(input int count);
      int bias;
      int roll;
      int w_insert;
      int w_serve;
      logic [1:0] cmd;
      logic [ID_W-1:0] id;
      logic [PRI_W-1:0] pri;
      bias = 1;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) bias = $urandom_range(0, 2);
         w_insert = (bias == 0) ? 60 : (bias == 1) ? 35 : 15;
         w_serve = (bias == 2) ? 45 : 20;
         roll = $urandom_range(0, 99);
         if (roll < w_insert) cmd = CMD_INSERT;
         else if (roll < w_insert + w_serve) cmd = CMD_SERVE;
         else if (roll[0]) cmd = CMD_REMOVE;
         else cmd = CMD_UPDATE;
         case ($urandom_range(0, 3))
            0: id = ID_W'($urandom);
            1: id = ID_W'($urandom_range(0, 7));
            default: id = (held_ids.size() != 0) ?
                          held_ids[$urandom_range(0, held_ids.size() - 1)] : ID_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0, 1, 2: pri = PRI_W'($urandom_range(0, 3));
            3, 4: pri = PRI_W'($urandom);
            default: pri = $urandom_range(0, 1) ? '1 : '0;
         endcase
         send_request(cmd, id, pri);
      end
      wait_for_answers();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_receiver_hold_off();
      test_full_queue();
      test_random_traffic(RANDOM_REQUESTS);
      wait_for_answers();
      repeat (2 * DEPTH + 10) @(posedge clock);
      $display("tb_top: %0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, responses_checked, error_count);
      $display("tb_top: statuses seen ok %0d, empty %0d, not found %0d, full %0d",
               status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
               status_seen[STATUS_NOT_FOUND], status_seen[STATUS_FULL]);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/spqr_pkg.sv
rtl/stable_priority_queue_with_removal_top.sv
dv/tb_top.sv
